>>> rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 4;
    localparam int REF_BYTES   = 4;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_REF_OFFSET     = 3'd4,
        REG_NEXT_OFFSET    = 3'd5,
        REG_RESOLVE_REF    = 3'd6,
        REG_BASE_ADDRESS   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_CUT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] care_mask;
        logic [4:0]  pattern_length;
        logic [7:0]  ref_offset;
        logic [31:0] next_offset;
        logic        resolve_ref;
        logic [63:0] base_address;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] match_pos;
        logic [31:0] ref_bytes;
    } t_res;

endpackage

>>> rtl/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module wbps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0]         paddr,
    input  logic [wbps_pkg::DATA_W-1:0]         pwdata,
    output logic [wbps_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output wbps_pkg::t_cfg                      o_cfg
);

    wbps_pkg::t_cfg   r_cfg;
    wbps_pkg::t_cfg   n_cfg;
    wbps_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = wbps_pkg::t_reg_idx'(paddr[wbps_pkg::ADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                wbps_pkg::REG_PATTERN_LOW:    n_cfg.pattern_low    = pwdata;
                wbps_pkg::REG_PATTERN_HIGH:   n_cfg.pattern_high   = pwdata;
                wbps_pkg::REG_CARE_MASK:      n_cfg.care_mask      = pwdata[15:0];
                wbps_pkg::REG_PATTERN_LENGTH: n_cfg.pattern_length = pwdata[4:0];
                wbps_pkg::REG_REF_OFFSET:     n_cfg.ref_offset     = pwdata[7:0];
                wbps_pkg::REG_NEXT_OFFSET:    n_cfg.next_offset    = pwdata[31:0];
                wbps_pkg::REG_RESOLVE_REF:    n_cfg.resolve_ref    = pwdata[0];
                wbps_pkg::REG_BASE_ADDRESS:   n_cfg.base_address   = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            wbps_pkg::REG_PATTERN_LOW:    prdata = r_cfg.pattern_low;
            wbps_pkg::REG_PATTERN_HIGH:   prdata = r_cfg.pattern_high;
            wbps_pkg::REG_CARE_MASK:      prdata = {48'd0, r_cfg.care_mask};
            wbps_pkg::REG_PATTERN_LENGTH: prdata = {59'd0, r_cfg.pattern_length};
            wbps_pkg::REG_REF_OFFSET:     prdata = {56'd0, r_cfg.ref_offset};
            wbps_pkg::REG_NEXT_OFFSET:    prdata = {32'd0, r_cfg.next_offset};
            wbps_pkg::REG_RESOLVE_REF:    prdata = {63'd0, r_cfg.resolve_ref};
            wbps_pkg::REG_BASE_ADDRESS:   prdata = r_cfg.base_address;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{64'd0, 64'd0, 16'hFFFF, 5'd1, 8'd0, 32'd0, 1'b0, 64'd0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Input register, byte history and window compare; tracks the first match
// and gathers the reference bytes, then hands one request per image onward.
// ----------------------------------------------------------------------------
module wbps_match (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wbps_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_data_byte,
    input  logic           i_first_byte,
    input  logic           i_last_byte,
    output logic           o_res_valid,
    input  logic           i_res_stall,
    output wbps_pkg::t_res o_res
);

    localparam int HIST = wbps_pkg::MAX_PATTERN - 1;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_first;
    logic        r_last;

    // history, newest first
    logic [7:0]  r_hist [HIST];

    // search state
    logic [31:0] r_pos;
    logic        r_seen;
    logic [31:0] r_mpos;
    logic [31:0] r_rbytes;
    logic [2:0]  r_rcnt;
    logic [31:0] n_pos;
    logic        n_seen;
    logic [31:0] n_mpos;
    logic [31:0] n_rbytes;
    logic [2:0]  n_rcnt;

    // result register
    logic           r_res_valid;
    wbps_pkg::t_res r_res;
    wbps_pkg::t_res n_res;

    logic        w_adv;
    logic        w_res_free;
    logic        w_load;

    logic [7:0]  w_win [wbps_pkg::MAX_PATTERN];
    logic [wbps_pkg::IDX_W-1:0] w_lenm1;
    logic        w_hit;
    logic [31:0] w_idx;
    logic        w_seen;
    logic [31:0] w_mpos;
    logic [31:0] w_rbytes;
    logic [2:0]  w_rcnt;
    logic [31:0] w_off;
    logic [31:0] w_hit_rbytes;
    logic [2:0]  w_hit_rcnt;

    assign w_res_free  = !r_res_valid || !i_res_stall;
    assign w_adv       = r_in_valid && (!r_last || w_res_free);
    assign o_stall     = r_in_valid && !w_adv;
    assign w_load      = i_valid && !o_stall;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // used pattern length minus one, clamped to the supported range
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_lenm1 = '0;
        end else if (i_cfg.pattern_length > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN)) begin
            w_lenm1 = wbps_pkg::IDX_W'(wbps_pkg::MAX_PATTERN - 1);
        end else begin
            w_lenm1 = wbps_pkg::IDX_W'(i_cfg.pattern_length - 5'd1);
        end
    end

    always_comb begin
        w_win[0] = r_byte;
        for (int j = 1; j < wbps_pkg::MAX_PATTERN; j++) begin
            w_win[j] = r_hist[j-1];
        end
    end

    // window compare
    always_comb begin
        logic [wbps_pkg::IDX_W-1:0] sel;
        logic [7:0]                 pat;
        w_hit = 1'b1;
        for (int k = 0; k < wbps_pkg::MAX_PATTERN; k++) begin
            sel = w_lenm1 - wbps_pkg::IDX_W'(k);
            pat = (k < 8) ? i_cfg.pattern_low[8*(k%8) +: 8]
                          : i_cfg.pattern_high[8*(k%8) +: 8];
            if (wbps_pkg::IDX_W'(k) <= w_lenm1 && i_cfg.care_mask[k] &&
                w_win[sel] != pat) begin
                w_hit = 1'b0;
            end
        end
    end

    // reference bytes already inside the window at the match
    always_comb begin
        logic [8:0]                 rel;
        logic [wbps_pkg::IDX_W-1:0] sel;
        w_hit_rbytes = '0;
        w_hit_rcnt   = '0;
        for (int k = 0; k < wbps_pkg::REF_BYTES; k++) begin
            rel = {1'b0, i_cfg.ref_offset} + 9'(k);
            sel = w_lenm1 - rel[wbps_pkg::IDX_W-1:0];
            if (rel <= {5'd0, w_lenm1}) begin
                w_hit_rbytes[8*k +: 8] = w_win[sel];
                w_hit_rcnt             = 3'(k + 1);
            end
        end
    end

    // search state update
    always_comb begin
        w_idx    = r_first ? '0 : r_pos;
        w_seen   = r_first ? 1'b0 : r_seen;
        w_mpos   = r_first ? '0 : r_mpos;
        w_rbytes = r_first ? '0 : r_rbytes;
        w_rcnt   = r_first ? '0 : r_rcnt;
        w_off    = w_idx - w_mpos;

        n_seen   = w_seen;
        n_mpos   = w_mpos;
        n_rbytes = w_rbytes;
        n_rcnt   = w_rcnt;
        if (w_seen) begin
            if (w_rcnt < 3'd4 &&
                w_off == {24'd0, i_cfg.ref_offset} + {29'd0, w_rcnt}) begin
                n_rbytes[8*w_rcnt[1:0] +: 8] = r_byte;
                n_rcnt                       = w_rcnt + 3'd1;
            end
        end else if (w_idx >= {28'd0, w_lenm1} && w_hit) begin
            n_seen   = 1'b1;
            n_mpos   = w_idx - {28'd0, w_lenm1};
            n_rbytes = w_hit_rbytes;
            n_rcnt   = w_hit_rcnt;
        end
        n_pos = w_idx + 32'd1;

        n_res.match_pos = n_mpos;
        n_res.ref_bytes = n_rbytes;
        if (!n_seen) begin
            n_res.status = wbps_pkg::STATUS_NONE;
        end else if (i_cfg.resolve_ref && n_rcnt < 3'd4) begin
            n_res.status = wbps_pkg::STATUS_CUT;
        end else begin
            n_res.status = wbps_pkg::STATUS_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_mpos      <= '0;
            r_rbytes    <= '0;
            r_rcnt      <= '0;
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv && r_last) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
            if (w_adv) begin
                if (r_last) begin
                    // image done, search starts over
                    r_pos    <= '0;
                    r_seen   <= 1'b0;
                    r_mpos   <= '0;
                    r_rbytes <= '0;
                    r_rcnt   <= '0;
                end else begin
                    r_pos    <= n_pos;
                    r_seen   <= n_seen;
                    r_mpos   <= n_mpos;
                    r_rbytes <= n_rbytes;
                    r_rcnt   <= n_rcnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte  <= i_data_byte;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
        if (w_adv) begin
            r_hist[0] <= r_byte;
            for (int j = 1; j < HIST; j++) begin
                r_hist[j] <= r_hist[j-1];
            end
        end
        if (w_adv && r_last) begin
            r_res <= n_res;
        end
    end

endmodule

>>> rtl/wbps_resolve.sv
// ----------------------------------------------------------------------------
// wbps_resolve
// Output register; forms the match or resolved address of a request.
// ----------------------------------------------------------------------------
module wbps_resolve (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wbps_pkg::t_cfg i_cfg,
    input  logic           i_res_valid,
    output logic           o_res_stall,
    input  wbps_pkg::t_res i_res,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_status,
    output logic [63:0]    o_address
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [63:0] r_address;
    logic [63:0] n_address;
    logic        w_load;

    assign o_res_stall = r_valid && i_stall;
    assign w_load      = i_res_valid && !o_res_stall;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_address   = r_address;

    always_comb begin
        n_address = '0;
        if (i_res.status == wbps_pkg::STATUS_FOUND) begin
            n_address = i_cfg.base_address + {32'd0, i_res.match_pos};
            if (i_cfg.resolve_ref) begin
                n_address = n_address
                          + {{32{i_cfg.next_offset[31]}}, i_cfg.next_offset}
                          + {{32{i_res.ref_bytes[31]}}, i_res.ref_bytes};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= i_res.status;
            r_address <= n_address;
        end
    end

endmodule

>>> rtl/wildcard_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// Streams image bytes, finds the first wildcard pattern match and reports
// the match address or the resolved relative reference at the image end.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// input     i_valid / o_stall       i_data_byte, i_first_byte, i_last_byte
// output    o_valid / i_stall       o_status, o_address
// config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one byte accepted per cycle unless o_stall is raised; the window compare
// and search update sit between the input register and the result register
// a result passes the input, result and output registers after its last byte
// reset clears the pipeline valids and the search state, and sets the registers to their defaults
// output stall holds back the input only when a last byte cannot hand over
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first_byte,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [63:0]                 o_address,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0] paddr,
    input  logic [wbps_pkg::DATA_W-1:0] pwdata,
    output logic [wbps_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    wbps_pkg::t_cfg w_cfg;
    wbps_pkg::t_res w_res;
    logic           w_res_valid;
    logic           w_res_stall;

    wbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wbps_match u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_res_valid  (w_res_valid),
        .i_res_stall  (w_res_stall),
        .o_res        (w_res)
    );

    wbps_resolve u_resolve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_res_valid (w_res_valid),
        .o_res_stall (w_res_stall),
        .i_res       (w_res),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_address   (o_address)
    );

endmodule

>>> dv/wbps_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wbps_scan_checker
// Watches the byte, result and register channels of the pattern scanner,
// keeps its own copy of the search and the registers, predicts the result of
// every image and compares each result that leaves the block with it.
// ----------------------------------------------------------------------------
module wbps_scan_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_first_byte,
    input  logic                        i_last_byte,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [1:0]                  i_status,
    input  logic [63:0]                 i_address,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [wbps_pkg::ADDR_W-1:0] paddr,
    input  logic [wbps_pkg::DATA_W-1:0] pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_found,
    output int                          o_no_match,
    output int                          o_cut
);
    import wbps_pkg::*;

    localparam int HIST_DEPTH = 32;

    typedef struct packed {
        t_status     status;
        logic [63:0] address;
    } t_scan_result;

    t_cfg         cfg;
    logic [7:0]   hist [HIST_DEPTH];
    logic [31:0]  scan_pos;
    logic         match_seen;
    logic [31:0]  match_pos;
    logic [31:0]  ref_bytes;
    int unsigned  ref_count;
    t_scan_result scan_results_q [$];

    task automatic report_mismatch(input string what);
        $display("%0t: scan check: %s", $time, what);
        o_errors++;
    endtask

    function automatic int unsigned used_len(input logic [4:0] n);
        if (n == 5'd0) return 1;
        if (n > MAX_PATTERN) return MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned k);
        if (k < 8) return cfg.pattern_low[8*k +: 8];
        return cfg.pattern_high[8*(k-8) +: 8];
    endfunction

    task automatic clear_search();
        scan_pos   = '0;
        match_seen = 1'b0;
        match_pos  = '0;
        ref_bytes  = '0;
        ref_count  = 0;
    endtask

    task automatic apply_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] v);
        case (t_reg_idx'(a[ADDR_W-1:3]))
            REG_PATTERN_LOW:    cfg.pattern_low    = v;
            REG_PATTERN_HIGH:   cfg.pattern_high   = v;
            REG_CARE_MASK:      cfg.care_mask      = v[15:0];
            REG_PATTERN_LENGTH: cfg.pattern_length = v[4:0];
            REG_REF_OFFSET:     cfg.ref_offset     = v[7:0];
            REG_NEXT_OFFSET:    cfg.next_offset    = v[31:0];
            REG_RESOLVE_REF:    cfg.resolve_ref    = v[0];
            REG_BASE_ADDRESS:   cfg.base_address   = v;
            default: ;
        endcase
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic first, input logic last);
        int unsigned  len;
        int unsigned  k;
        logic [31:0]  idx;
        logic [31:0]  off;
        logic [31:0]  rel;
        logic         hit;
        t_scan_result r;
        len = used_len(cfg.pattern_length);
        if (first) clear_search();
        idx = scan_pos;
        for (k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = b;
        if (match_seen) begin
            off = idx - match_pos;
            if (ref_count < 4 && off >= 32'(cfg.ref_offset) &&
                off - 32'(cfg.ref_offset) == ref_count) begin
                ref_bytes[8*ref_count +: 8] = b;
                ref_count++;
            end
        end else if (idx >= len - 1) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                if (cfg.care_mask[k] && hist[len-1-k] != pattern_byte(k)) hit = 1'b0;
            end
            if (hit) begin
                match_seen = 1'b1;
                match_pos  = idx - (len - 1);
                ref_bytes  = '0;
                ref_count  = 0;
                // reference bytes already inside the window
                for (k = 0; k < 4; k++) begin
                    rel = 32'(cfg.ref_offset) + k;
                    if (rel <= len - 1) begin
                        ref_bytes[8*k +: 8] = hist[len-1-rel];
                        ref_count++;
                    end
                end
            end
        end
        scan_pos = idx + 1;
        if (last) begin
            r.address = '0;
            if (!match_seen) begin
                r.status = STATUS_NONE;
            end else if (cfg.resolve_ref && ref_count < 4) begin
                r.status = STATUS_CUT;
            end else begin
                r.status  = STATUS_FOUND;
                r.address = cfg.base_address + {32'd0, match_pos};
                if (cfg.resolve_ref) begin
                    r.address += {{32{cfg.next_offset[31]}}, cfg.next_offset} +
                                 {{32{ref_bytes[31]}}, ref_bytes};
                end
            end
            scan_results_q.push_back(r);
            clear_search();
        end
    endtask

    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            cfg.pattern_low    = '0;
            cfg.pattern_high   = '0;
            cfg.care_mask      = 16'hFFFF;
            cfg.pattern_length = 5'd1;
            cfg.ref_offset     = '0;
            cfg.next_offset    = '0;
            cfg.resolve_ref    = 1'b0;
            cfg.base_address   = '0;
            foreach (hist[k]) hist[k] = '0;
            clear_search();
            scan_results_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (scan_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d address %h",
                                              i_status, i_address));
                end else begin
                    want = scan_results_q.pop_front();
                    o_checked++;
                    case (want.status)
                        STATUS_FOUND: o_found++;
                        STATUS_NONE:  o_no_match++;
                        default:      o_cut++;
                    endcase
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    if (i_address !== want.address)
                        report_mismatch($sformatf("address %h, expected %h",
                                                  i_address, want.address));
                end
            end
            if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
            if (i_req_valid && !i_req_stall) scan_byte(i_data_byte, i_first_byte, i_last_byte);
        end
        o_pending = scan_results_q.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte stream stimulus for the wildcard byte pattern scanner: a short
// directed set of images, then random images with embedded patterns under
// many register settings, with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import wbps_pkg::*;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic [7:0]        i_data_byte  = '0;
    logic              i_first_byte = 1'b0;
    logic              i_last_byte  = 1'b0;
    logic              i_stall      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    wire               o_stall;
    wire               o_valid;
    wire  [1:0]        o_status;
    wire  [63:0]       o_address;
    wire  [DATA_W-1:0] prdata;
    wire               pready;

    int errors, pending, checked, n_found, n_no_match, n_cut;
    int idle_pct = 22;
    int bytes_sent, images_sent, settings_used;

    // current register values, used to build images that can match
    logic [63:0] pat_low, pat_high;
    logic [15:0] care;
    logic [4:0]  plen = 5'd1;
    logic [7:0]  roff;

    wildcard_byte_pattern_scanner_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_address    (o_address),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    wbps_scan_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_status     (o_status),
        .i_address    (o_address),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_found      (n_found),
        .o_no_match   (n_no_match),
        .o_cut        (n_cut)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    function automatic logic [7:0] pattern_at(input int unsigned k);
        if (k < 8) return pat_low[8*k +: 8];
        return pat_high[8*(k-8) +: 8];
    endfunction

    task automatic write_reg(input t_reg_idx r, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] cm, input logic [4:0] ln,
                              input logic [7:0] ro, input logic [31:0] nx,
                              input logic rr, input logic [63:0] ba);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, {48'd0, cm});
        write_reg(REG_PATTERN_LENGTH, {59'd0, ln});
        write_reg(REG_REF_OFFSET, {56'd0, ro});
        write_reg(REG_NEXT_OFFSET, {32'd0, nx});
        write_reg(REG_RESOLVE_REF, {63'd0, rr});
        write_reg(REG_BASE_ADDRESS, ba);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pat_low  = lo;
        pat_high = hi;
        care     = cm;
        plen     = ln;
        roff     = ro;
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        logic ok;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first;
        i_last_byte  <= last;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        bytes_sent++;
        if (last) images_sent++;
    endtask

    // image written left to right, closed by its last byte
    task automatic send_seq(input logic [127:0] seq, input int n, input logic mark_first);
        int k;
        for (k = 0; k < n; k++)
            send_byte(seq[8*(n-1-k) +: 8], mark_first && k == 0, k == n - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_setup();
        int unsigned pick;
        logic [4:0]  ln;
        logic [7:0]  ro;
        logic [31:0] nx;
        logic [63:0] ba;
        logic [15:0] cm;
        pick = $urandom_range(99);
        if (pick < 6)       ln = 5'd0;
        else if (pick < 12) ln = 5'($urandom_range(17, 31));
        else if (pick < 20) ln = 5'd16;
        else                ln = 5'($urandom_range(1, 8));
        pick = $urandom_range(99);
        if (pick < 70)      ro = 8'($urandom_range(0, 12));
        else if (pick < 88) ro = 8'($urandom_range(13, 40));
        else                ro = 8'($urandom_range(200, 255));
        pick = $urandom_range(3);
        if (pick == 0)      nx = 32'h7FFF_FFFF;
        else if (pick == 1) nx = 32'h8000_0000;
        else                nx = $urandom;
        pick = $urandom_range(3);
        if (pick == 0)      ba = 64'd0;
        else if (pick == 1) ba = {64{1'b1}};
        else                ba = {$urandom, $urandom};
        pick = $urandom_range(3);
        if (pick == 0)      cm = 16'hFFFF;
        else if (pick == 1) cm = 16'h0000;
        else                cm = 16'($urandom);
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, cm, ln, ro, nx,
                   1'($urandom_range(2) != 0), ba);
    endtask

    // mostly images carrying the pattern, some plain noise, some with a
    // missing first or last mark or a restart in the middle
    task automatic random_image();
        logic [7:0]  img [$];
        int unsigned n, at, k, eff, restart_at;
        logic        embed, alphabet, mark_first, mark_last;
        eff      = (plen == 5'd0) ? 1 : ((plen > MAX_PATTERN) ? MAX_PATTERN : plen);
        embed    = $urandom_range(3) != 0;
        alphabet = $urandom_range(1);
        at       = $urandom_range(0, 5);
        if (embed)
            n = at + eff + ((roff <= 40) ? $urandom_range(0, roff + 6) : $urandom_range(0, 6));
        else if ($urandom_range(9) != 0)
            n = $urandom_range(1, 24);
        else
            n = $urandom_range(25, 64);
        for (k = 0; k < n; k++)
            img.push_back(alphabet ? pattern_at($urandom_range(0, eff - 1)) : 8'($urandom));
        if (embed) begin
            for (k = 0; k < eff; k++)
                if (care[k]) img[at+k] = pattern_at(k);
        end
        mark_first = $urandom_range(9) != 0;
        mark_last  = $urandom_range(14) != 0;
        restart_at = ($urandom_range(19) == 0) ? $urandom_range(0, n - 1) : n;
        for (k = 0; k < n; k++)
            send_byte(img[k], (k == 0 && mark_first) || k == restart_at,
                      mark_last && k == n - 1);
    endtask

    initial begin
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, one-byte image, then an image without a first mark
        send_seq(128'h00, 1, 1'b1);
        send_seq(128'hFF_FF, 2, 1'b0);
        drain();
        // zero length, top base address
        load_setup(64'hAB, 64'd0, 16'hFFFF, 5'd0, 8'd0, 32'd0, 1'b0, {64{1'b1}});
        send_seq(128'hAB, 1, 1'b1);
        drain();
        // wildcard in the middle, reference partly in the window, cut short, too short
        load_setup(64'h30_20_10, 64'd0, 16'hFFFD, 5'd3, 8'd1, 32'h8000_0000, 1'b1, 64'd0);
        send_seq(128'h10_99_30_04_03_02, 6, 1'b1);
        send_seq(128'h10_55_30, 3, 1'b1);
        send_seq(128'h10_55, 2, 1'b1);
        drain();
        // only a high pattern byte cares, top offsets
        load_setup(64'd0, {64{1'b1}}, 16'h0100, 5'd9, 8'd255, 32'h7FFF_FFFF, 1'b0,
                   64'h8000_0000_0000_0000);
        send_seq(128'h00_00_00_00_00_00_00_00_FF, 9, 1'b1);
        drain();

        while (bytes_sent < 400) begin
            random_setup();
            idle_pct    = (settings_used % 5 == 3) ? 0 : 22;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 60) random_image();
            drain();
        end

        $display("scanned %0d bytes in %0d closed images under %0d register settings",
                 bytes_sent, images_sent, settings_used);
        $display("checked %0d results: %0d found, %0d no match, %0d reference cut off",
                 checked, n_found, n_no_match, n_cut);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
